/* hdl/tgf_pkg.sv */
`default_nettype none
package tgf_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int TILE_BITS   = 16;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int COORD_BITS  = 8;
   localparam int DIM_BITS    = 9;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_RECT  = 2'd2;
   localparam logic [1:0] OP_DISC  = 2'd3;

   localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_READ,
      MODE_RECT,
      MODE_DISC
   } mode_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_SETUP,
      B_READ,
      B_WALK,
      B_DRAIN,
      B_RESP
   } back_state_type;

   // one classified command, clipped to the grid
   typedef struct packed {
      mode_type                mode;
      logic                    org;
      logic [TILE_BITS-1:0]    tile;
      logic [COORD_BITS-1:0]   lo_x;
      logic [COORD_BITS-1:0]   hi_x;
      logic [COORD_BITS-1:0]   lo_y;
      logic [COORD_BITS-1:0]   hi_y;
      logic [COORD_BITS-1:0]   cx;
      logic [COORD_BITS-1:0]   cy;
      logic [2*COORD_BITS-1:0] rsq;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

/* hdl/tgf_front.sv */
`default_nettype none
module tgf_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic signed [9:0]             req_pos_x,
   input  wire logic signed [9:0]             req_pos_y,
   input  wire logic [8:0]                    req_rect_w,
   input  wire logic [8:0]                    req_rect_h,
   input  wire logic [7:0]                    req_radius,
   input  wire logic signed [15:0]            req_tile_value,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [8:0]                    csr_data,
   input  wire tgf_pkg::queue_status_type     q_status,
   input  wire logic                          clearing,
   output logic                               push,
   output tgf_pkg::job_type                   push_job,
   output logic [tgf_pkg::DIM_BITS-1:0]       used_width
);

   logic [8:0] map_width_ff, map_width_in;
   logic [8:0] map_height_ff, map_height_in;
   logic [8:0] uw, uh;
   logic       org;
   logic [7:0] x8, y8, uw_m1, uh_m1;
   logic [9:0] ex, ey, dxs, dys;
   logic [7:0] rect_hx, rect_hy, disc_lx, disc_ly, disc_hx, disc_hy;

   assign csr_ready = 1'b1;

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tgf_pkg::REG_MAP_WIDTH:  map_width_in  = csr_data;
            tgf_pkg::REG_MAP_HEIGHT: map_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 9'(tgf_pkg::MAX_WIDTH);
         map_height_ff <= 9'(tgf_pkg::MAX_HEIGHT);
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // saturate to the store size
   assign uw = (map_width_ff > 9'(tgf_pkg::MAX_WIDTH)) ? 9'(tgf_pkg::MAX_WIDTH) : map_width_ff;
   assign uh = (map_height_ff > 9'(tgf_pkg::MAX_HEIGHT)) ? 9'(tgf_pkg::MAX_HEIGHT)
                                                         : map_height_ff;
   assign used_width = uw;

   assign org = !req_pos_x[9] && !req_pos_y[9] &&
                (req_pos_x[8:0] < uw) && (req_pos_y[8:0] < uh);

   // coordinates only matter once the origin is inside
   assign x8    = req_pos_x[7:0];
   assign y8    = req_pos_y[7:0];
   assign uw_m1 = 8'(uw - 9'd1);
   assign uh_m1 = 8'(uh - 9'd1);

   assign ex      = {1'b0, req_pos_x[8:0]} + {1'b0, req_rect_w};
   assign ey      = {1'b0, req_pos_y[8:0]} + {1'b0, req_rect_h};
   assign rect_hx = (ex <= {1'b0, uw}) ? 8'(ex - 10'd1) : uw_m1;
   assign rect_hy = (ey <= {1'b0, uh}) ? 8'(ey - 10'd1) : uh_m1;

   assign dxs     = {2'b00, x8} + {2'b00, req_radius};
   assign dys     = {2'b00, y8} + {2'b00, req_radius};
   assign disc_lx = (x8 >= req_radius) ? (x8 - req_radius) : 8'd0;
   assign disc_ly = (y8 >= req_radius) ? (y8 - req_radius) : 8'd0;
   assign disc_hx = (dxs < {1'b0, uw}) ? dxs[7:0] : uw_m1;
   assign disc_hy = (dys < {1'b0, uh}) ? dys[7:0] : uh_m1;

   always_comb begin
      push_job      = '0;
      push_job.mode = tgf_pkg::MODE_NONE;
      push_job.org  = org;
      push_job.tile = req_tile_value[tgf_pkg::TILE_BITS-1:0];
      push_job.lo_x = x8;
      push_job.hi_x = x8;
      push_job.lo_y = y8;
      push_job.hi_y = y8;
      push_job.cx   = x8;
      push_job.cy   = y8;
      push_job.rsq  = (2*tgf_pkg::COORD_BITS)'(req_radius)
                      * (2*tgf_pkg::COORD_BITS)'(req_radius);
      if (org) begin
         case (req_opcode)
            tgf_pkg::OP_WRITE: push_job.mode = tgf_pkg::MODE_RECT;
            tgf_pkg::OP_READ:  push_job.mode = tgf_pkg::MODE_READ;
            tgf_pkg::OP_RECT: begin
               if (req_rect_w != 9'd0 && req_rect_h != 9'd0) begin
                  push_job.mode = tgf_pkg::MODE_RECT;
               end
               push_job.hi_x = rect_hx;
               push_job.hi_y = rect_hy;
            end
            tgf_pkg::OP_DISC: begin
               push_job.mode = tgf_pkg::MODE_DISC;
               push_job.lo_x = disc_lx;
               push_job.hi_x = disc_hx;
               push_job.lo_y = disc_ly;
               push_job.hi_y = disc_hy;
            end
            default: push_job.mode = tgf_pkg::MODE_NONE;
         endcase
      end
   end

   assign busy = clearing || q_status.full;
   assign push = start && !busy;

endmodule
`default_nettype wire

/* hdl/tgf_queue.sv */
`default_nettype none
module tgf_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire tgf_pkg::job_type          push_job,
   input  wire logic                      pop,
   output tgf_pkg::job_type               head_job,
   output tgf_pkg::queue_status_type      status
);

   tgf_pkg::job_type entry_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule
`default_nettype wire

/* hdl/tgf_back.sv */
`default_nettype none
module tgf_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tgf_pkg::job_type              head_job,
   input  wire tgf_pkg::queue_status_type     q_status,
   input  wire logic [tgf_pkg::DIM_BITS-1:0]  used_width,
   output logic                               pop,
   output logic                               clearing,
   output logic                               rsp_valid,
   output logic signed [15:0]                 rsp_read_value,
   output logic                               rsp_origin_in_bounds
);

   localparam int AW = tgf_pkg::ADDR_BITS;
   localparam int TB = tgf_pkg::TILE_BITS;
   localparam int CB = tgf_pkg::COORD_BITS;

   logic [TB-1:0] mem [0:tgf_pkg::STORE_DEPTH-1];

   tgf_pkg::back_state_type state_ff, state_in;
   tgf_pkg::job_type        job_ff, job_in;

   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [CB-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [AW-1:0]   row_base_ff, row_base_in;
   logic            p1_valid_ff, p1_valid_in;
   logic [AW-1:0]   p1_addr_ff, p1_addr_in;
   logic [CB-1:0]   p1_adx_ff, p1_adx_in, p1_ady_ff, p1_ady_in;
   logic            p2_valid_ff;
   logic [AW-1:0]   p2_addr_ff;
   logic [2*CB-1:0] p2_dxsq_ff, p2_dysq_ff;
   logic [2*CB:0]   dist_sq;
   logic [TB-1:0]   rdata_ff;
   logic [AW-1:0]   raddr;
   logic            we;
   logic [AW-1:0]   waddr;
   logic [TB-1:0]   wdata;
   logic [AW-1:0]   row_prod;

   // row 255 of a 256 wide grid still fits the address
   assign row_prod = AW'(job_ff.lo_y) * AW'(used_width);
   assign dist_sq  = {1'b0, p2_dxsq_ff} + {1'b0, p2_dysq_ff};
   assign raddr    = row_base_ff + AW'(job_ff.lo_x);
   assign clearing = (state_ff == tgf_pkg::B_CLEAR);

   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      clr_cnt_in     = clr_cnt_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      row_base_in    = row_base_ff;
      p1_valid_in    = 1'b0;
      p1_addr_in     = row_base_ff + AW'(cur_x_ff);
      p1_adx_in      = (cur_x_ff >= job_ff.cx) ? (cur_x_ff - job_ff.cx)
                                               : (job_ff.cx - cur_x_ff);
      p1_ady_in      = (cur_y_ff >= job_ff.cy) ? (cur_y_ff - job_ff.cy)
                                               : (job_ff.cy - cur_y_ff);
      pop            = 1'b0;
      rsp_valid      = 1'b0;
      we             = 1'b0;
      waddr          = p2_addr_ff;
      wdata          = job_ff.tile;

      // fill writes leave the last pipeline stage
      if (p2_valid_ff && (job_ff.mode != tgf_pkg::MODE_DISC || dist_sq <= {1'b0, job_ff.rsq}))
      begin
         we = 1'b1;
      end

      case (state_ff)
         tgf_pkg::B_CLEAR: begin
            we         = 1'b1;
            waddr      = clr_cnt_ff;
            wdata      = '1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == '1) begin
               state_in = tgf_pkg::B_IDLE;
            end
         end
         tgf_pkg::B_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               job_in   = head_job;
               state_in = tgf_pkg::B_SETUP;
            end
         end
         tgf_pkg::B_SETUP: begin
            row_base_in = row_prod;
            cur_x_in    = job_ff.lo_x;
            cur_y_in    = job_ff.lo_y;
            case (job_ff.mode)
               tgf_pkg::MODE_READ: state_in = tgf_pkg::B_READ;
               tgf_pkg::MODE_RECT: state_in = tgf_pkg::B_WALK;
               tgf_pkg::MODE_DISC: state_in = tgf_pkg::B_WALK;
               default:            state_in = tgf_pkg::B_RESP;
            endcase
         end
         tgf_pkg::B_READ: begin
            state_in = tgf_pkg::B_RESP;
         end
         tgf_pkg::B_WALK: begin
            p1_valid_in = 1'b1;
            if (cur_x_ff == job_ff.hi_x) begin
               cur_x_in = job_ff.lo_x;
               if (cur_y_ff == job_ff.hi_y) begin
                  state_in = tgf_pkg::B_DRAIN;
               end else begin
                  cur_y_in    = cur_y_ff + CB'(1);
                  row_base_in = row_base_ff + AW'(used_width);
               end
            end else begin
               cur_x_in = cur_x_ff + CB'(1);
            end
         end
         tgf_pkg::B_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff) begin
               state_in = tgf_pkg::B_RESP;
            end
         end
         tgf_pkg::B_RESP: begin
            rsp_valid = 1'b1;
            state_in  = tgf_pkg::B_IDLE;
         end
         default: state_in = tgf_pkg::B_IDLE;
      endcase
   end

   assign rsp_read_value       = (job_ff.mode == tgf_pkg::MODE_READ) ? 16'(signed'(rdata_ff))
                                                                     : 16'hFFFF;
   assign rsp_origin_in_bounds = job_ff.org;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tgf_pkg::B_CLEAR;
         clr_cnt_ff  <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      row_base_ff <= row_base_in;
      p1_addr_ff  <= p1_addr_in;
      p1_adx_ff   <= p1_adx_in;
      p1_ady_ff   <= p1_ady_in;
      p2_addr_ff  <= p1_addr_ff;
      p2_dxsq_ff  <= (2*CB)'(p1_adx_ff) * (2*CB)'(p1_adx_ff);
      p2_dysq_ff  <= (2*CB)'(p1_ady_ff) * (2*CB)'(p1_ady_ff);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule
`default_nettype wire

/* hdl/tile_grid_rect_circle_fill.sv */
`default_nettype none
// tile grid store, 256 x 256 tiles of 16 bits, cell (x, y) at x + y * width
// command channel: a word is taken on a clock edge with start high and busy low;
//   opcode 0 writes one tile, 1 reads one, 2 fills a rectangle, 3 fills a disc
// result channel: one word per command, shown for a single cycle with rsp_valid;
//   the receiver cannot stall it, so results simply leave in command order
// csr channel: map_width (index 0) and map_height (index 1), csr_ready always high;
//   write only while no command is outstanding
// front end classifies each command and clips the fill box to the grid, a two-deep
//   queue lets it take the next word while the back end is still walking cells
// back end walks the clipped box one cell per clock through a two-stage pipe
//   (address and distance, then squares), writing the tile memory
// the back end takes one command at a time: SETUP, then READ for a read, or WALK
//   and DRAIN for a write or fill, then RESP; out-of-grid or empty ones go to RESP
// it pops the next queue word only once back in IDLE after the result word
// busy is high when the queue holds two words or the clearing pass runs
// reset: registers go to 256 x 256 and a clearing pass writes the empty tile to
//   every cell with busy high; csr writes are taken meanwhile
module tile_grid_rect_circle_fill (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [9:0]  req_pos_x,
   input  wire logic signed [9:0]  req_pos_y,
   input  wire logic [8:0]         req_rect_w,
   input  wire logic [8:0]         req_rect_h,
   input  wire logic [7:0]         req_radius,
   input  wire logic signed [15:0] req_tile_value,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_read_value,
   output logic                    rsp_origin_in_bounds,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [8:0]         csr_data
);

   tgf_pkg::job_type                push_job;
   tgf_pkg::job_type                head_job;
   tgf_pkg::queue_status_type       q_status;
   logic                            push;
   logic                            pop;
   logic                            clearing;
   logic [tgf_pkg::DIM_BITS-1:0]    used_width;

   // accept, classify and clip
   tgf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_rect_w     (req_rect_w),
      .req_rect_h     (req_rect_h),
      .req_radius     (req_radius),
      .req_tile_value (req_tile_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_status       (q_status),
      .clearing       (clearing),
      .push           (push),
      .push_job       (push_job),
      .used_width     (used_width)
   );

   // decouples the two halves
   tgf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // cell walk, tile memory and result word
   tgf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_job             (head_job),
      .q_status             (q_status),
      .used_width           (used_width),
      .pop                  (pop),
      .clearing             (clearing),
      .rsp_valid            (rsp_valid),
      .rsp_read_value       (rsp_read_value),
      .rsp_origin_in_bounds (rsp_origin_in_bounds)
   );

endmodule
`default_nettype wire
